### rtl/tlvncl_pkg.sv
// ----------------------------------------------------------------------------
// tlvncl_pkg
// shared constants and types for the tlv name component locator
// ----------------------------------------------------------------------------
package tlvncl_pkg;

    // block limits
    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int MAX_COMPONENTS  = 255;
    // largest name length that fits the 13-bit byte counters
    localparam int NAME_LEN_FIELD_MAX = 8191;
    localparam int NAME_LEN_LIMIT =
        (MAX_BLOCK_BYTES < NAME_LEN_FIELD_MAX) ? MAX_BLOCK_BYTES : NAME_LEN_FIELD_MAX;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_NAME_TYPE = 1'b0;
    localparam logic [0:0] REG_COMP_TYPE = 1'b1;
    localparam logic [7:0] NAME_TYPE_RESET = 8'd7;
    localparam logic [7:0] COMP_TYPE_RESET = 8'd8;

    // variable-length number lead bytes
    localparam logic [7:0] VARNUM_2BYTE = 8'd253;
    localparam logic [7:0] VARNUM_4BYTE = 8'd254;
    localparam logic [7:0] VARNUM_BAD   = 8'd255;

    // saturation point of byte positions and offsets
    localparam logic [11:0] POS_MAX = 12'hFFF;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_NAME_TYPE = 3'd1,
        ST_BAD_LENGTH    = 3'd2,
        ST_NAME_EXCEEDS  = 3'd3,
        ST_BAD_COMP_TYPE = 3'd4,
        ST_COMP_OVERRUN  = 3'd5
    } status_t;

endpackage

### rtl/tlv_name_component_locator.sv
// ----------------------------------------------------------------------------
// tlv_name_component_locator
// byte-serial parser of one tlv-encoded name block with component lookup
// ----------------------------------------------------------------------------
// The block takes one byte of an encoded name per item, marked on the final
// byte, and walks the name: outer type code, variable-length name length,
// then the component entries (type, length, value). It counts components and
// records the value offset and length of the component at target_position,
// which is sampled with the first byte of each block. On the item carrying
// last_byte it issues one result (status, count, found, offset, length) and
// starts over for the next block; other items give no result. The whole
// per-byte update is one pass of counter logic from the parse registers
// into themselves and the result register, so an item can be accepted
// every cycle while in_ready is high. The result register frees in_ready as
// soon as the pending result is taken (or in the same cycle). The two type
// codes are set through the apb port (0x0 name type, 0x4 component type)
// and should only be changed between blocks.
// ----------------------------------------------------------------------------
module tlv_name_component_locator (
    input  logic                           clk,
    input  logic                           rst_n,
    // byte stream in
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [7:0]                     target_position,
    // result out
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     status,
    output logic [7:0]                     component_count,
    output logic                           found,
    output logic [11:0]                    component_offset,
    output logic [12:0]                    component_length,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tlvncl_pkg::ADDR_W-1:0]  paddr,
    input  logic [tlvncl_pkg::DATA_W-1:0]  pwdata,
    output logic [tlvncl_pkg::DATA_W-1:0]  prdata,
    output logic                           pready
);
    import tlvncl_pkg::*;

    // parse phase
    typedef enum logic [2:0] {
        PH_NTYPE = 3'd0,    // expect the name type byte
        PH_NLEN  = 3'd1,    // first byte of the name length
        PH_NLENX = 3'd2,    // extra bytes of the name length
        PH_CTYPE = 3'd3,    // component type byte
        PH_CLEN  = 3'd4,    // first byte of a component length
        PH_CLENX = 3'd5,    // extra bytes of a component length
        PH_VALUE = 3'd6,    // component value bytes
        PH_DONE  = 3'd7     // name finished or failed, rest ignored
    } phase_t;

    // configuration registers
    logic [7:0]  name_type_reg, name_type_next;
    logic [7:0]  comp_type_reg, comp_type_next;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  nbytes_reg, nbytes_next;
    logic [12:0] name_left_reg, name_left_next;
    logic [12:0] value_left_reg, value_left_next;
    logic [11:0] pos_reg, pos_next;
    logic [7:0]  comps_reg, comps_next;
    logic [7:0]  want_reg, want_next;
    logic        fflag_reg, fflag_next;
    logic [11:0] foff_reg, foff_next;
    logic [12:0] flen_reg, flen_next;
    status_t     err_reg, err_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [7:0]  count_reg, count_next;
    logic        found_reg, found_next;
    logic [11:0] offset_reg, offset_next;
    logic [12:0] length_reg, length_next;

    // per-byte working values
    logic        accept;
    logic        cfg_write;
    logic        name_done;
    logic        comp_done;
    logic [31:0] len_val;
    logic [31:0] acc_shift;
    logic [2:0]  need;
    logic [12:0] start_wide;
    status_t     blk_status;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_COMP_TYPE) ? {24'd0, comp_type_reg}
                                                   : {24'd0, name_type_reg};

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign component_count  = count_reg;
    assign found            = found_reg;
    assign component_offset = offset_reg;
    assign component_length = length_reg;

    // configuration writes
    always_comb
    begin
        name_type_next = name_type_reg;
        comp_type_next = comp_type_reg;
        if (cfg_write)
        begin
            if (paddr[2] == REG_NAME_TYPE)
                name_type_next = pwdata[7:0];
            else
                comp_type_next = pwdata[7:0];
        end
    end

    // one byte of parsing
    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        nbytes_next     = nbytes_reg;
        name_left_next  = name_left_reg;
        value_left_next = value_left_reg;
        pos_next        = pos_reg;
        comps_next      = comps_reg;
        want_next       = want_reg;
        fflag_next      = fflag_reg;
        foff_next       = foff_reg;
        flen_next       = flen_reg;
        err_next        = err_reg;
        name_done       = 1'b0;
        comp_done       = 1'b0;
        len_val         = 32'd0;
        need            = (data_byte == VARNUM_2BYTE) ? 3'd2 : 3'd4;
        acc_shift       = {acc_reg[23:0], data_byte};
        start_wide      = {1'b0, pos_reg} + 13'd1;

        if (phase_reg == PH_NTYPE)
            want_next = target_position;

        case (phase_reg)
            PH_NTYPE:
            begin
                if (data_byte != name_type_reg)
                begin
                    err_next   = ST_BAD_NAME_TYPE;
                    phase_next = PH_DONE;
                end
                else
                    phase_next = PH_NLEN;
            end
            PH_NLEN:
            begin
                if (data_byte == VARNUM_BAD)
                begin
                    err_next   = ST_BAD_LENGTH;
                    phase_next = PH_DONE;
                end
                else if (data_byte < VARNUM_2BYTE)
                begin
                    name_done = 1'b1;
                    len_val   = {24'd0, data_byte};
                end
                else
                begin
                    acc_next    = 32'd0;
                    nbytes_next = need;
                    phase_next  = PH_NLENX;
                end
            end
            PH_NLENX:
            begin
                acc_next    = acc_shift;
                nbytes_next = nbytes_reg - 3'd1;
                if (nbytes_next == 3'd0)
                begin
                    name_done = 1'b1;
                    len_val   = acc_shift;
                end
            end
            PH_CTYPE:
            begin
                name_left_next = name_left_reg - 13'd1;
                if (data_byte != comp_type_reg)
                begin
                    err_next   = ST_BAD_COMP_TYPE;
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (comps_reg < 8'(MAX_COMPONENTS))
                        comps_next = comps_reg + 8'd1;
                    // a type byte with nothing after it in the name
                    if (name_left_next == 13'd0)
                    begin
                        err_next   = ST_BAD_LENGTH;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_CLEN;
                end
            end
            PH_CLEN:
            begin
                name_left_next = name_left_reg - 13'd1;
                if (data_byte == VARNUM_BAD)
                begin
                    err_next   = ST_BAD_LENGTH;
                    phase_next = PH_DONE;
                end
                else if (data_byte < VARNUM_2BYTE)
                begin
                    comp_done = 1'b1;
                    len_val   = {24'd0, data_byte};
                end
                else if (name_left_next < {10'd0, need})
                begin
                    err_next   = ST_BAD_LENGTH;
                    phase_next = PH_DONE;
                end
                else
                begin
                    acc_next    = 32'd0;
                    nbytes_next = need;
                    phase_next  = PH_CLENX;
                end
            end
            PH_CLENX:
            begin
                name_left_next = name_left_reg - 13'd1;
                acc_next       = acc_shift;
                nbytes_next    = nbytes_reg - 3'd1;
                if (nbytes_next == 3'd0)
                begin
                    comp_done = 1'b1;
                    len_val   = acc_shift;
                end
            end
            PH_VALUE:
            begin
                name_left_next  = name_left_reg - 13'd1;
                value_left_next = value_left_reg - 13'd1;
                if (value_left_next == 13'd0)
                    phase_next = (name_left_next != 13'd0) ? PH_CTYPE : PH_DONE;
            end
            default:
            begin
            end
        endcase

        // name length complete
        if (name_done)
        begin
            if (len_val > 32'(NAME_LEN_LIMIT))
            begin
                err_next   = ST_NAME_EXCEEDS;
                phase_next = PH_DONE;
            end
            else
            begin
                name_left_next = len_val[12:0];
                phase_next     = (len_val != 32'd0) ? PH_CTYPE : PH_DONE;
            end
        end

        // component length complete
        if (comp_done)
        begin
            if (len_val > {19'd0, name_left_next})
            begin
                err_next   = ST_COMP_OVERRUN;
                phase_next = PH_DONE;
            end
            else
            begin
                // first component at the wanted index
                if (!fflag_reg && comps_reg != 8'd0 && (comps_reg - 8'd1) == want_reg)
                begin
                    fflag_next = 1'b1;
                    foff_next  = start_wide[12] ? POS_MAX : start_wide[11:0];
                    flen_next  = len_val[12:0];
                end
                value_left_next = len_val[12:0];
                if (len_val == 32'd0)
                    phase_next = (name_left_next != 13'd0) ? PH_CTYPE : PH_DONE;
                else
                    phase_next = PH_VALUE;
            end
        end

        if (pos_reg < POS_MAX)
            pos_next = pos_reg + 12'd1;

        // final status of the block as it stands after this byte
        if (err_next != ST_OK)
            blk_status = err_next;
        else if (phase_next inside {PH_NLEN, PH_NLENX})
            blk_status = ST_BAD_LENGTH;
        else if (phase_next != PH_DONE)
            blk_status = ST_NAME_EXCEEDS;
        else
            blk_status = ST_OK;

        status_next = blk_status;
        count_next  = (blk_status == ST_OK) ? comps_next : 8'd0;
        found_next  = fflag_next;
        offset_next = fflag_next ? foff_next : 12'd0;
        length_next = fflag_next ? flen_next : 13'd0;

        // block ends: start over
        if (last_byte)
        begin
            phase_next      = PH_NTYPE;
            acc_next        = 32'd0;
            nbytes_next     = 3'd0;
            name_left_next  = 13'd0;
            value_left_next = 13'd0;
            pos_next        = 12'd0;
            comps_next      = 8'd0;
            want_next       = 8'd0;
            fflag_next      = 1'b0;
            foff_next       = 12'd0;
            flen_next       = 13'd0;
            err_next        = ST_OK;
        end
    end

    // result handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && last_byte)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_type_reg  <= NAME_TYPE_RESET;
            comp_type_reg  <= COMP_TYPE_RESET;
            phase_reg      <= PH_NTYPE;
            acc_reg        <= 32'd0;
            nbytes_reg     <= 3'd0;
            name_left_reg  <= 13'd0;
            value_left_reg <= 13'd0;
            pos_reg        <= 12'd0;
            comps_reg      <= 8'd0;
            want_reg       <= 8'd0;
            fflag_reg      <= 1'b0;
            foff_reg       <= 12'd0;
            flen_reg       <= 13'd0;
            err_reg        <= ST_OK;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            count_reg      <= 8'd0;
            found_reg      <= 1'b0;
            offset_reg     <= 12'd0;
            length_reg     <= 13'd0;
        end
        else
        begin
            name_type_reg <= name_type_next;
            comp_type_reg <= comp_type_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                nbytes_reg     <= nbytes_next;
                name_left_reg  <= name_left_next;
                value_left_reg <= value_left_next;
                pos_reg        <= pos_next;
                comps_reg      <= comps_next;
                want_reg       <= want_next;
                fflag_reg      <= fflag_next;
                foff_reg       <= foff_next;
                flen_reg       <= flen_next;
                err_reg        <= err_next;
                if (last_byte)
                begin
                    status_reg <= status_next;
                    count_reg  <= count_next;
                    found_reg  <= found_next;
                    offset_reg <= offset_next;
                    length_reg <= length_next;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // the last byte of a block always leaves a result and a fresh parser
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (out_valid_reg && phase_reg == PH_NTYPE))
        else $error("last byte did not produce a result or restart the parse");

    // a failed block reports no component count
    a_count_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (count_reg == 8'd0))
        else $error("component count given with a failing status");

    // offset and length are zero unless the component was found
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (offset_reg == 12'd0 && length_reg == 13'd0))
        else $error("offset or length set without a found component");

    // nothing counted or recorded before the name type byte
    a_fresh_block: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NTYPE) |-> (comps_reg == 8'd0 && !fflag_reg && err_reg == ST_OK))
        else $error("parse state not clear at block start");
`endif

endmodule

### sim/tlv_name_component_locator_test.sv
// ----------------------------------------------------------------------------
// tlv_name_component_locator_test
// self-checking bench for the byte-serial tlv name component locator
// ----------------------------------------------------------------------------
// Feeds encoded name blocks one byte per item and follows every accepted byte
// with a local model of the name walk. Each result is checked field by field
// against the oldest expected one. Directed blocks cover every status and
// the corner cases. Register tests change the type codes through the apb
// port. Long blocks cover count and offset saturation. The random part is
// mostly well-formed names with random content, plus broken blocks and noise.
// Both handshakes idle at random. One phase holds off results long enough to
// stall the input.
// ----------------------------------------------------------------------------
module tlv_name_component_locator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tlvncl_pkg::*;

    localparam int TAIL_CYCLES  = 8;       // settle time after the last result
    localparam int HOLD_CYCLES  = 150;     // long result hold-off
    localparam int LIMIT_CYCLES = 600000;  // run limit, several times the slowest run
    localparam int RANDOM_BYTES = 650;
    localparam int RANDOM_NAMES = 40;

    // walk phases of the local model
    typedef enum logic [2:0] {
        W_NAME_TYPE,
        W_NAME_LEN,
        W_NAME_LEN_EXT,
        W_COMP_TYPE,
        W_COMP_LEN,
        W_COMP_LEN_EXT,
        W_VALUE,
        W_DONE
    } walk_phase_t;

    // one expected lookup result
    typedef struct packed {
        status_t     status;
        logic [7:0]  count;
        logic        found;
        logic [11:0] offset;
        logic [12:0] length;
    } location_t;

    // dut ports
    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [7:0]        target_position;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        status;
    logic [7:0]        component_count;
    logic              found;
    logic [11:0]       component_offset;
    logic [12:0]       component_length;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // shadow of the configuration registers
    logic [7:0]  name_code;
    logic [7:0]  comp_code;

    // local model of the name walk
    walk_phase_t walk;
    logic [31:0] num_acc;
    int          num_left;
    logic [31:0] name_left;
    logic [31:0] value_left;
    int          byte_pos;
    int          comps;
    logic [7:0]  wanted;
    logic        hit;
    logic [11:0] hit_offset;
    logic [12:0] hit_length;
    status_t     first_error;

    // results predicted but not yet seen at the output
    location_t   due_locations[$];

    // block under construction: name body, then the whole block
    logic [7:0]  body_q[$];
    logic [7:0]  block_q[$];

    // handshake pacing
    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    int          hold_asks = 0;

    int          mismatches = 0;
    int          cycles = 0;

    tlv_name_component_locator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .target_position  (target_position),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .component_count  (component_count),
        .found            (found),
        .component_offset (component_offset),
        .component_length (component_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     due_locations.size());
            $display("FAIL tlv_name_component_locator");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // local model of the name walk
    // ------------------------------------------------------------------------

    task automatic clear_walk();
        walk        = W_NAME_TYPE;
        num_acc     = '0;
        num_left    = 0;
        name_left   = '0;
        value_left  = '0;
        byte_pos    = 0;
        comps       = 0;
        wanted      = '0;
        hit         = 1'b0;
        hit_offset  = '0;
        hit_length  = '0;
        first_error = ST_OK;
    endtask

    // first error wins, the rest of the block is ignored
    task automatic abort_walk(input status_t code);
        first_error = code;
        walk        = W_DONE;
    endtask

    task automatic end_component();
        walk = (name_left != 0) ? W_COMP_TYPE : W_DONE;
    endtask

    task automatic take_name_length(input logic [31:0] n);
        if (n > NAME_LEN_LIMIT)
            abort_walk(ST_NAME_EXCEEDS);
        else
        begin
            name_left = n;
            walk      = (n != 0) ? W_COMP_TYPE : W_DONE;
        end
    endtask

    // records the wanted component unless its value runs past the name
    task automatic take_comp_length(input logic [31:0] n);
        if (n > name_left)
            abort_walk(ST_COMP_OVERRUN);
        else
        begin
            if (!hit && comps != 0 && 8'(comps - 1) == wanted)
            begin
                hit        = 1'b1;
                hit_offset = (byte_pos + 1 > POS_MAX) ? POS_MAX : 12'(byte_pos + 1);
                hit_length = n[12:0];
            end
            value_left = n;
            if (n == 0)
                end_component();
            else
                walk = W_VALUE;
        end
    endtask

    // lead byte of a variable-length number
    task automatic start_number(input logic [7:0] b, input bit is_name);
        int need;
        if (b == VARNUM_BAD)
            abort_walk(ST_BAD_LENGTH);
        else if (b < VARNUM_2BYTE)
        begin
            if (is_name)
                take_name_length({24'd0, b});
            else
                take_comp_length({24'd0, b});
        end
        else
        begin
            need = (b == VARNUM_2BYTE) ? 2 : 4;
            // a component length must fit in what is left of the name
            if (!is_name && name_left < need)
                abort_walk(ST_BAD_LENGTH);
            else
            begin
                num_acc  = '0;
                num_left = need;
                walk     = is_name ? W_NAME_LEN_EXT : W_COMP_LEN_EXT;
            end
        end
    endtask

    // one accepted byte; a last byte adds the expected result
    task automatic walk_name_byte(input logic [7:0] b, input logic lst, input logic [7:0] tp);
        location_t loc;
        status_t   st;
        if (walk == W_NAME_TYPE)
            wanted = tp;
        case (walk)
            W_NAME_TYPE:
            begin
                if (b != name_code)
                    abort_walk(ST_BAD_NAME_TYPE);
                else
                    walk = W_NAME_LEN;
            end
            W_NAME_LEN:
                start_number(b, 1'b1);
            W_NAME_LEN_EXT:
            begin
                num_acc = {num_acc[23:0], b};
                num_left--;
                if (num_left == 0)
                    take_name_length(num_acc);
            end
            W_COMP_TYPE:
            begin
                name_left--;
                if (b != comp_code)
                    abort_walk(ST_BAD_COMP_TYPE);
                else
                begin
                    if (comps < MAX_COMPONENTS)
                        comps++;
                    // a type byte that ends the name leaves no room for a length
                    if (name_left == 0)
                        abort_walk(ST_BAD_LENGTH);
                    else
                        walk = W_COMP_LEN;
                end
            end
            W_COMP_LEN:
            begin
                name_left--;
                start_number(b, 1'b0);
            end
            W_COMP_LEN_EXT:
            begin
                name_left--;
                num_acc = {num_acc[23:0], b};
                num_left--;
                if (num_left == 0)
                    take_comp_length(num_acc);
            end
            W_VALUE:
            begin
                name_left--;
                value_left--;
                if (value_left == 0)
                    end_component();
            end
            default:
                ;  // trailing bytes and bytes after an error
        endcase
        if (byte_pos < int'(POS_MAX))
            byte_pos++;
        if (lst)
        begin
            st = first_error;
            if (st == ST_OK)
            begin
                if (walk == W_NAME_LEN || walk == W_NAME_LEN_EXT)
                    st = ST_BAD_LENGTH;
                else if (walk != W_DONE)
                    st = ST_NAME_EXCEEDS;
            end
            loc.status = st;
            loc.count  = (st == ST_OK) ? 8'(comps) : 8'd0;
            loc.found  = hit;
            loc.offset = hit ? hit_offset : 12'd0;
            loc.length = hit ? hit_length : 13'd0;
            due_locations.push_back(loc);
            clear_walk();
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    task automatic check_location();
        location_t want;
        if (due_locations.size() == 0)
        begin
            mismatches++;
            $display("%0t ns: result with none expected, got status %0d count %0d",
                     $time, status, component_count);
        end
        else
        begin
            want = due_locations.pop_front();
            compare_field("status", want.status, status);
            compare_field("component_count", want.count, component_count);
            compare_field("found", want.found, found);
            compare_field("component_offset", want.offset, component_offset);
            compare_field("component_length", want.length, component_length);
        end
    endtask

    // result sink: random stalls, or a long hold-off when a test asks for one
    initial
    begin : result_sink
        int stall;
        int holds_done;
        holds_done = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_asks)
            begin
                holds_done = hold_asks;
                out_ready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (recv_idle)
            begin
                stall = $urandom_range(0, 13);
                if (stall > 0)
                begin
                    out_ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_location();
        end
    end

    // ------------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------------

    // one item; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [7:0] tp);
        int gap;
        gap = send_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        = 1'b1;
        data_byte       = b;
        last_byte       = lst;
        target_position = tp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        walk_name_byte(b, lst, tp);
        @(negedge clk);
    endtask

    // sends block_q; the wanted position rides on the first byte, noise on the rest
    task automatic send_block(input logic [7:0] target);
        int n;
        n = block_q.size();
        for (int i = 0; i < n; i++)
            send_byte(block_q[i], i == n - 1, (i == 0) ? target : 8'($urandom_range(0, 255)));
    endtask

    // stop offering bytes and let every due result arrive
    task automatic drain();
        in_valid = 1'b0;
        while (due_locations.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------

    // write then read back one type code register
    task automatic write_code(input logic [0:0] reg_index, input logic [7:0] value);
        logic [ADDR_W-1:0] addr;
        addr    = {reg_index, 2'b00};
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        if (reg_index == REG_NAME_TYPE)
            name_code = value;
        else
            comp_code = value;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        compare_field("register readback", {24'd0, value}, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_codes(input logic [7:0] name_value, input logic [7:0] comp_value);
        drain();
        write_code(REG_NAME_TYPE, name_value);
        write_code(REG_COMP_TYPE, comp_value);
    endtask

    // ------------------------------------------------------------------------
    // block builders
    // ------------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b, input bit to_body);
        if (to_body)
            body_q.push_back(b);
        else
            block_q.push_back(b);
    endtask

    // variable-length number: form 0 one byte, 1 two-byte, 2 four-byte,
    // widened where the value needs it
    task automatic put_number(input logic [31:0] n, input int form, input bit to_body);
        int f;
        f = form;
        if (f == 0 && n >= VARNUM_2BYTE)
            f = 1;
        if (f == 1 && n > 32'hFFFF)
            f = 2;
        case (f)
            0:
                put_byte(n[7:0], to_body);
            1:
            begin
                put_byte(VARNUM_2BYTE, to_body);
                put_byte(n[15:8], to_body);
                put_byte(n[7:0], to_body);
            end
            default:
            begin
                put_byte(VARNUM_4BYTE, to_body);
                put_byte(n[31:24], to_body);
                put_byte(n[23:16], to_body);
                put_byte(n[15:8], to_body);
                put_byte(n[7:0], to_body);
            end
        endcase
    endtask

    task automatic add_component(input int vlen, input int form);
        put_byte(comp_code, 1'b1);
        put_number(vlen, form, 1'b1);
        repeat (vlen) put_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // wraps body_q into a name block, with the given number of trailing bytes
    task automatic close_name(input int form, input int trailing);
        block_q.delete();
        put_byte(name_code, 1'b0);
        put_number(body_q.size(), form, 1'b0);
        foreach (body_q[i])
            block_q.push_back(body_q[i]);
        repeat (trailing) put_byte(8'($urandom_range(0, 255)), 1'b0);
        body_q.delete();
    endtask

    function automatic int pick_form();
        int r;
        r = $urandom_range(0, 9);
        return (r < 7) ? 0 : (r < 9) ? 1 : 2;
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd252;
            2:       return 8'($urandom_range(253, 255));
            default: return 8'($urandom_range(0, 252));
        endcase
    endfunction

    // random name, mostly well formed; broken ones are damaged after assembly
    task automatic send_random_block(input bit may_break);
        int ncomp;
        int vlen;
        int keep;
        logic [7:0] target;
        ncomp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 5);
        for (int i = 0; i < ncomp; i++)
        begin
            vlen = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 6);
            add_component(vlen, pick_form());
        end
        close_name(pick_form(), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        target = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, ncomp))
                                             : 8'($urandom_range(0, 255));
        if (may_break && $urandom_range(0, 9) < 3)
        begin
            case ($urandom_range(0, 3))
                0:  // one byte replaced by noise
                    block_q[$urandom_range(0, block_q.size() - 1)] = 8'($urandom_range(0, 255));
                1:  // cut short
                begin
                    keep = $urandom_range(1, block_q.size());
                    while (block_q.size() > keep)
                        void'(block_q.pop_back());
                end
                2:  // one byte replaced by a code that steers the walk
                begin
                    case ($urandom_range(0, 4))
                        0: block_q[$urandom_range(0, block_q.size() - 1)] = comp_code;
                        1: block_q[$urandom_range(0, block_q.size() - 1)] = VARNUM_2BYTE;
                        2: block_q[$urandom_range(0, block_q.size() - 1)] = VARNUM_4BYTE;
                        3: block_q[$urandom_range(0, block_q.size() - 1)] = VARNUM_BAD;
                        default: block_q[$urandom_range(0, block_q.size() - 1)] = 8'd0;
                    endcase
                end
                default:  // pure noise
                begin
                    block_q.delete();
                    repeat ($urandom_range(1, 8)) block_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        send_block(target);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every status and corner case, with the type codes left at reset
    task automatic test_reset_codes();
        // empty name
        close_name(0, 0);
        send_block(8'd0);
        // zero-length component found, trailing bytes ignored
        add_component(3, 0);
        add_component(0, 0);
        add_component(2, 0);
        close_name(0, 2);
        send_block(8'd1);
        // four-byte length numbers for name and component
        add_component(4, 2);
        close_name(2, 0);
        send_block(8'd0);
        // wrong outer type
        block_q = {name_code ^ 8'h01, 8'd0};
        send_block(8'd0);
        // reserved lead byte on the name length
        block_q = {name_code, VARNUM_BAD};
        send_block(8'd0);
        // block ends inside the name length number
        block_q = {name_code, VARNUM_2BYTE, 8'h00};
        send_block(8'd0);
        // a single-byte block
        block_q = {name_code};
        send_block(8'd0);
        // block ends inside the name
        block_q = {name_code, 8'd5, comp_code, 8'd1};
        send_block(8'd0);
        // name length above the limit, two- and four-byte forms
        block_q = {name_code, VARNUM_2BYTE, 8'h10, 8'h01, comp_code};
        send_block(8'd0);
        block_q = {name_code, VARNUM_4BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_block(8'd0);
        // wrong component type after the wanted one is found
        add_component(1, 0);
        put_byte(comp_code ^ 8'h80, 1'b1);
        put_byte(8'd0, 1'b1);
        close_name(0, 0);
        send_block(8'd0);
        // type byte ends the name
        block_q = {name_code, 8'd1, comp_code};
        send_block(8'd0);
        // component length number longer than the name has left
        block_q = {name_code, 8'd3, comp_code, VARNUM_2BYTE, 8'h00};
        send_block(8'd0);
        // reserved lead byte on a component length
        block_q = {name_code, 8'd2, comp_code, VARNUM_BAD};
        send_block(8'd0);
        // component value past the name: the overrunning one is not found,
        // an earlier one still is
        block_q = {name_code, 8'd6, comp_code, 8'd1, 8'hAA, comp_code, 8'd5, 8'hBB};
        send_block(8'd1);
        block_q = {name_code, 8'd6, comp_code, 8'd1, 8'hAA, comp_code, 8'd5, 8'hBB};
        send_block(8'd0);
    endtask

    // type codes at their extremes, including the reserved lead values
    task automatic test_register_codes();
        logic [7:0] codes[4][2];
        codes = '{'{8'd255, 8'd253}, '{8'd0, 8'd252}, '{8'd252, 8'd0}, '{8'd254, 8'd255}};
        for (int i = 0; i < 4; i++)
        begin
            set_codes(codes[i][0], codes[i][1]);
            repeat (3) send_random_block(1'b0);
            block_q = {name_code ^ 8'h10, 8'd0};
            send_block(8'd0);
            block_q = {name_code, 8'd2, comp_code ^ 8'h01, 8'd0};
            send_block(8'd0);
        end
        set_codes(NAME_TYPE_RESET, COMP_TYPE_RESET);
    endtask

    // count saturates; the wanted index at and past the saturation point
    task automatic test_many_components();
        repeat (258) add_component(0, 0);
        close_name(1, 0);
        send_block(8'd254);
        repeat (256) add_component(0, 0);
        close_name(1, 1);
        send_block(8'd255);
    endtask

    // block past 4096 bytes: offsets saturate at the end
    task automatic test_long_block();
        add_component(4070, 1);
        repeat (10) add_component(0, 0);
        close_name(1, 2);
        send_block(8'd10);
    endtask

    // long result hold-off while bytes keep coming, then a full drain
    task automatic test_backpressure();
        drain();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_asks++;
        repeat (12) send_random_block(1'b0);
        drain();
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // random names in phases, the type codes changed between phases
    task automatic test_random_blocks();
        int sent_bytes;
        int names;
        sent_bytes = 0;
        names      = 0;
        while (sent_bytes < RANDOM_BYTES || names < RANDOM_NAMES)
        begin
            if (names % 8 == 0)
                set_codes(pick_code(), pick_code());
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            send_random_block(1'b1);
            sent_bytes += block_q.size();
            names++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin : main_sequence
        in_valid        = 1'b0;
        data_byte       = '0;
        last_byte       = 1'b0;
        target_position = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rst_n           = 1'b0;
        name_code       = NAME_TYPE_RESET;
        comp_code       = COMP_TYPE_RESET;
        clear_walk();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_reset_codes();
        test_register_codes();
        test_many_components();
        test_long_block();
        test_backpressure();
        test_random_blocks();
        drain();

        if (mismatches == 0)
            $display("PASS tlv_name_component_locator");
        else
            $display("FAIL tlv_name_component_locator");
        $finish;
    end

endmodule

### tlv_name_component_locator.f
rtl/tlvncl_pkg.sv
rtl/tlv_name_component_locator.sv
sim/tlv_name_component_locator_test.sv
